### rtl/core/esk_pkg.sv
// Shared types and constants for the exchange sort block.
// No dependencies; imported by every module of the block.
package esk_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         tag;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] key_res;
    logic [7:0]         tag_res;
    logic               last_res;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RDJ,
    ST_CUR,
    ST_CMP,
    ST_WJ,
    ST_ERD,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // input open
    logic rdj;    // read entry j
    logic cur;    // take entry j as current, read j+1
    logic cmp;    // compare/swap entry i against current
    logic wj;     // write current back to j, read j+1
    logic erd;    // read entry 0 for output
    logic emit;   // load output register, read next
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic n_one;
    logic i_end;
    logic j_end;
    logic k_end;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/exchange_sort_keys_with_tags_top.sv
// Exchange sort, n entries per set (n <= 16): load takes one item per cycle.
// Sort (n > 1): one compare/swap per cycle on the entry memory, which has one
// read and one write port; a one-entry set skips it. Emit reads entry 0, then
// sends them in order, holding on stall. No item is taken during sort or emit.
// Reset (rst_ni low, async): empty set, no overflow, no result pending.
// Depends on esk_pkg, esk_ctrl, esk_dp.
module exchange_sort_keys_with_tags_top import esk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: load -> (per j: take j, scan i, write back j) -> emit; one entry skips the sort.
  esk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Entry memory plus current-minimum register; a swap writes the old
  // current entry to slot i and keeps entry i as current.
  esk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/core/esk_ctrl.sv
// Sequencer for load, sort and emit phases.
// Depends on esk_pkg.
module esk_ctrl import esk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (sts_i.in_valid && sts_i.in_last) begin
          state_d = sts_i.n_one ? ST_ERD : ST_RDJ;
        end
      end
      ST_RDJ: state_d = ST_CUR;
      ST_CUR: state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.i_end) state_d = ST_WJ;
      end
      ST_WJ: state_d = sts_i.j_end ? ST_ERD : ST_CUR;
      ST_ERD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.k_end) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD: cmd_o.load = 1'b1;
      ST_RDJ:  cmd_o.rdj  = 1'b1;
      ST_CUR:  cmd_o.cur  = 1'b1;
      ST_CMP:  cmd_o.cmp  = 1'b1;
      ST_WJ:   cmd_o.wj   = 1'b1;
      ST_ERD:  cmd_o.erd  = 1'b1;
      ST_EMIT: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/core/esk_dp.sv
// Datapath: entry memory, sort registers, counters and output register.
// Depends on esk_pkg.
module esk_dp import esk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  entry_t mem_q [MAX_ITEMS];

  entry_t            rd_q, cur_q, wdata;
  logic [IDX_W-1:0]  i_q, j_q, k_q, raddr, waddr, n_m1, j_nx;
  logic [CNT_W-1:0]  count_q, n_q;
  logic              ovf_q, set_ovf_q, out_valid_q;
  out_item_t         out_q;
  logic              accept, full, less, ren, we, out_free;

  assign accept   = cmd_i.load & in_valid_i;
  assign full     = (count_q == CNT_W'(MAX_ITEMS));
  assign less     = $signed(rd_q.key) < $signed(cur_q.key);
  assign n_m1     = IDX_W'(n_q - CNT_W'(1));
  assign j_nx     = j_q + IDX_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = count_q[IDX_W-1:0];
    wdata = cur_q;
    if (accept && !full) begin
      we    = 1'b1;
      wdata = '{key: in_item_i.key, tag: in_item_i.tag};
    end else if (cmd_i.cmp && less) begin
      we    = 1'b1;
      waddr = i_q;
    end else if (cmd_i.wj) begin
      we    = 1'b1;
      waddr = j_q;
    end
  end

  // single read port
  always_comb begin
    ren   = 1'b0;
    raddr = j_q;
    if (cmd_i.rdj) begin
      ren = 1'b1;
    end else if (cmd_i.cur || cmd_i.wj) begin
      ren   = 1'b1;
      raddr = j_nx;
    end else if (cmd_i.cmp) begin
      ren   = (i_q != n_m1);
      raddr = i_q + IDX_W'(1);
    end else if (cmd_i.erd) begin
      ren   = 1'b1;
      raddr = '0;
    end else if (cmd_i.emit) begin
      ren   = 1'b1;
      raddr = k_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (ren) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur || (cmd_i.cmp && less)) cur_q <= rd_q;
    if (cmd_i.emit) begin
      out_q <= '{key_res: rd_q.key, tag_res: rd_q.tag,
                 last_res: (k_q == n_m1), overflow: set_ovf_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      n_q         <= CNT_W'(1);
      ovf_q       <= 1'b0;
      set_ovf_q   <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (in_item_i.last) begin
          count_q   <= '0;
          n_q       <= full ? count_q : count_q + CNT_W'(1);
          ovf_q     <= 1'b0;
          set_ovf_q <= ovf_q | full;
          j_q       <= '0;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.cur) i_q <= j_nx;
      else if (cmd_i.cmp && (i_q != n_m1)) i_q <= i_q + IDX_W'(1);
      if (cmd_i.wj) j_q <= j_nx;
      if (cmd_i.erd) k_q <= '0;
      else if (cmd_i.emit) k_q <= k_q + IDX_W'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o = '{in_valid: in_valid_i, in_last: in_item_i.last, n_one: (count_q == '0),
                   i_end: (i_q == n_m1), j_end: (j_nx == n_m1), k_end: (k_q == n_m1),
                   out_free: out_free};

  assign in_stall_o  = !cmd_i.load;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/core/esk_checker.sv
// Port-level checks for the exchange sort top level, bound to it below.
// Depends on esk_pkg and exchange_sort_keys_with_tags_top.
module esk_checker import esk_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // while a run is mid-way, input stays closed
  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_res |-> in_stall_o)
    else $error("input open during emit");

  // last item ends loading
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last |=> in_stall_o)
    else $error("input open after last item");

  // overflow flag constant within a run
  a_ovf_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_res |=>
      !out_valid_o || (out_item_o.overflow == $past(out_item_o.overflow)))
    else $error("overflow flag changed within run");

endmodule

bind exchange_sort_keys_with_tags_top esk_checker u_esk_checker (.*);
